FILE: design/dtoi_pkg.sv
// Shared types and constants of the decimal text to integer converter.
package dtoi_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_FORMAT = 2'd1,
		STATUS_EMPTY  = 2'd2,
		STATUS_RANGE  = 2'd3
	} status_t;

	// Register indexes, selected by address bit 3 (registers sit 8 bytes apart).
	localparam logic REG_SIGNED_TARGET = 1'b0;
	localparam logic REG_MAX_VALUE     = 1'b1;

	localparam int unsigned ADDR_BITS = 4;
	localparam int unsigned DATA_BITS = 64;
	localparam int unsigned CHAR_BITS = 8;

	localparam logic [63:0] MAX_VALUE_RESET = 64'd2147483647;

	// Character codes the parser reacts to.
	localparam logic [CHAR_BITS-1:0] CHAR_SPACE  = 8'h20;
	localparam logic [CHAR_BITS-1:0] CHAR_DEL    = 8'h7F;
	localparam logic [CHAR_BITS-1:0] CHAR_MINUS  = 8'h2D;
	localparam logic [CHAR_BITS-1:0] CHAR_POINT  = 8'h2E;
	localparam logic [CHAR_BITS-1:0] CHAR_COMMA  = 8'h2C;
	localparam logic [CHAR_BITS-1:0] CHAR_ZERO   = 8'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_NINE   = 8'h39;

	// Parse flags carried from one character to the next.
	typedef struct packed {
		logic seen_digit;
		logic minus_seen;
		logic point_seen;
		logic format_error;
		logic too_large;
		logic fraction_nonzero;
	} flags_t;

endpackage

FILE: design/decimal_text_to_integer.sv
// Top level of the decimal text to integer converter.
//
//   Channel   Direction  Handshake              Word
//   input     in         in_valid / in_stall    character, last
//   output    out        out_valid / out_stall  magnitude, negative, status
//   config    in         APB psel/penable       signed_target @0x0, max_value @0x8
//
// One character word is accepted every cycle unless the input side stalls. Each
// word is captured in an input register, from where the parse step updates the
// flags and accumulator and, on a word marked last, loads the result register
// that drives the outputs.
// The input side stalls only when a last character sits in the input register
// while the result register still holds an untaken result.
// Reset clears the parse state, the valid flags and sets the registers to a
// signed target with a maximum of 2147483647.
module decimal_text_to_integer #(
	parameter int unsigned VALUE_BITS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dtoi_pkg::CHAR_BITS-1:0] character,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [VALUE_BITS-1:0]          magnitude,
	output logic                           negative,
	output logic [1:0]                     status,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dtoi_pkg::ADDR_BITS-1:0] paddr,
	input  logic [dtoi_pkg::DATA_BITS-1:0] pwdata,
	output logic [dtoi_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready
);
	import dtoi_pkg::*;

	logic                  signed_target;
	logic [63:0]           max_value;

	// Input register stage.
	logic                  valid_s1;
	logic [CHAR_BITS-1:0]  character_s1;
	logic                  last_s1;

	// Parse state across the characters of one string.
	flags_t                flags_q;
	logic [VALUE_BITS-1:0] acc_q;

	flags_t                flags_next;
	logic [VALUE_BITS-1:0] acc_next;
	logic [VALUE_BITS-1:0] res_magnitude;
	logic                  res_negative;
	logic [1:0]            res_status;

	// Result register.
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] magnitude_q;
	logic                  negative_q;
	logic [1:0]            status_q;

	logic                  retire;

	dtoi_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.signed_target (signed_target),
		.max_value     (max_value)
	);

	dtoi_step #(
		.VALUE_BITS (VALUE_BITS)
	) u_step (
		.flags         (flags_q),
		.acc           (acc_q),
		.character     (character_s1),
		.last          (last_s1),
		.signed_target (signed_target),
		.max_value     (max_value),
		.flags_next    (flags_next),
		.acc_next      (acc_next),
		.res_magnitude (res_magnitude),
		.res_negative  (res_negative),
		.res_status    (res_status)
	);

	// A word that produces no result never waits; a last word waits for a free
	// result register, which is free when empty or being taken this cycle.
	assign in_stall = valid_s1 && last_s1 && out_valid_q && out_stall;
	assign retire   = valid_s1 && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			character_s1 <= character;
			last_s1      <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			acc_q   <= '0;
		end else if (retire) begin
			flags_q <= flags_next;
			acc_q   <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && last_s1) begin
			magnitude_q <= res_magnitude;
			negative_q  <= res_negative;
			status_q    <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign magnitude = magnitude_q;
	assign negative  = negative_q;
	assign status    = status_q;

endmodule

FILE: design/dtoi_regs.sv
// Configuration register file of the decimal text to integer converter.
module dtoi_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dtoi_pkg::ADDR_BITS-1:0] paddr,
	input  logic [dtoi_pkg::DATA_BITS-1:0] pwdata,
	output logic [dtoi_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready,
	output logic                           signed_target,
	output logic [63:0]                    max_value
);
	import dtoi_pkg::*;

	logic signed_target_q;
	logic [63:0] max_value_q;
	logic wr_en;
	logic reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_target_q <= 1'b1;
			max_value_q     <= MAX_VALUE_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_SIGNED_TARGET: signed_target_q <= pwdata[0];
				REG_MAX_VALUE:     max_value_q     <= pwdata;
				default:           ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_SIGNED_TARGET: prdata = {{(DATA_BITS-1){1'b0}}, signed_target_q};
			REG_MAX_VALUE:     prdata = max_value_q;
			default:           prdata = '0;
		endcase
	end

	assign signed_target = signed_target_q;
	assign max_value     = max_value_q;

endmodule

FILE: design/dtoi_step.sv
// Per-character parse update and end-of-string result formation.
module dtoi_step #(
	parameter int unsigned VALUE_BITS = 64
) (
	input  dtoi_pkg::flags_t                 flags,
	input  logic [VALUE_BITS-1:0]            acc,
	input  logic [dtoi_pkg::CHAR_BITS-1:0]   character,
	input  logic                             last,
	input  logic                             signed_target,
	input  logic [63:0]                      max_value,
	output dtoi_pkg::flags_t                 flags_next,
	output logic [VALUE_BITS-1:0]            acc_next,
	output logic [VALUE_BITS-1:0]            res_magnitude,
	output logic                             res_negative,
	output logic [1:0]                       res_status
);
	import dtoi_pkg::*;

	logic                  is_space;
	logic                  is_minus;
	logic                  is_point;
	logic                  is_digit;
	logic [3:0]            digit;
	logic [VALUE_BITS+3:0] acc_times_ten;
	logic                  acc_ovf;
	flags_t                f;
	logic [VALUE_BITS-1:0] a;
	logic [63:0]           acc_wide;
	logic                  over_max;

	assign is_space = (character < CHAR_SPACE) || (character == CHAR_DEL)
		|| (character == CHAR_SPACE);
	assign is_minus = (character == CHAR_MINUS);
	assign is_point = (character == CHAR_POINT) || (character == CHAR_COMMA);
	assign is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
	assign digit    = 4'(character - CHAR_ZERO);

	// acc * 10 + digit as two shifts and adds; any bit above the value width is overflow.
	assign acc_times_ten = ({4'b0, acc} << 3) + ({4'b0, acc} << 1)
		+ {{VALUE_BITS{1'b0}}, digit};
	assign acc_ovf = |acc_times_ten[VALUE_BITS+3:VALUE_BITS];

	// Flags and accumulator after this character, before any end-of-string clear.
	always_comb begin
		f = flags;
		a = acc;
		if (!flags.format_error) begin
			priority if (is_space) begin
				if (flags.seen_digit) f.format_error = 1'b1;
			end else if (is_minus) begin
				if (signed_target && !flags.seen_digit && !flags.minus_seen)
					f.minus_seen = 1'b1;
				else
					f.format_error = 1'b1;
			end else if (is_point) begin
				if (!flags.point_seen && flags.seen_digit)
					f.point_seen = 1'b1;
				else
					f.format_error = 1'b1;
			end else if (!is_digit) begin
				f.format_error = 1'b1;
			end else begin
				f.seen_digit = 1'b1;
				priority if (flags.point_seen) begin
					if (digit != 4'd0) f.fraction_nonzero = 1'b1;
				end else if (flags.too_large || acc_ovf) begin
					f.too_large = 1'b1;
					a = '1;
				end else begin
					a = acc_times_ten[VALUE_BITS-1:0];
				end
			end
		end
	end

	assign acc_wide = 64'(a);
	assign over_max = f.too_large || (acc_wide > max_value)
		|| ((acc_wide == max_value) && f.fraction_nonzero);

	always_comb begin
		res_magnitude = '0;
		res_negative  = 1'b0;
		priority if (f.format_error) begin
			res_status = STATUS_FORMAT;
		end else if (!f.seen_digit) begin
			res_status = STATUS_EMPTY;
		end else if (over_max) begin
			res_status    = STATUS_RANGE;
			res_magnitude = max_value[VALUE_BITS-1:0];
			res_negative  = f.minus_seen;
		end else begin
			res_status    = STATUS_OK;
			res_magnitude = a;
			res_negative  = f.minus_seen;
		end
	end

	// The string's last character restarts the parse.
	assign flags_next = last ? '0 : f;
	assign acc_next   = last ? '0 : a;

endmodule

FILE: verif/decimal_text_to_integer_tb.sv
// Self-checking testbench for the decimal text to integer converter.
`timescale 1ns / 100ps

module decimal_text_to_integer_tb;
	import dtoi_pkg::*;

	localparam int unsigned VALUE_BITS     = 64;
	localparam logic [63:0] VALUE_MASK     = {64{1'b1}} >> (64 - VALUE_BITS);
	localparam logic [63:0] DECIMAL_BASE   = 64'd10;
	localparam int unsigned WORD_TARGET    = 1650;
	localparam int unsigned PHASE_COUNT    = 8;
	localparam int unsigned QUIET_PHASE    = 2;
	localparam int unsigned RESET_CYCLES   = 12;
	// A result leaves the block through the input register and the result
	// register, so this margin covers any word still in the pipeline.
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned MAX_REPORTED   = 10;
	localparam int unsigned IDLE_PERCENT   = 14;

	typedef struct packed {
		logic [VALUE_BITS-1:0] magnitude;
		logic                  negative;
		status_t               status;
	} result_t;

	// One directed string: an optional leading byte that a string literal cannot
	// carry, the text, and a hand-written result where it is obvious.
	typedef struct {
		int          lead;
		string       text;
		bit          typed;
		logic [63:0] magnitude;
		bit          negative;
		status_t     status;
	} text_case_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [CHAR_BITS-1:0]  character;
	logic                  last;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [VALUE_BITS-1:0] magnitude;
	logic                  negative;
	logic [1:0]            status;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_BITS-1:0]  paddr;
	logic [DATA_BITS-1:0]  pwdata;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;

	// Shadow copy of the converter: its registers, its parse flags and the
	// integer part built so far.
	bit          cfg_signed;
	logic [63:0] cfg_max;
	flags_t      text_flags;
	logic [63:0] int_part;

	result_t     pending_results [$];
	logic [7:0]  text_bytes [$];
	result_t     predicted;
	result_t     wanted;
	result_t     typed_result;
	bit          use_typed;
	bit          idle_enabled;
	int unsigned failures = 0;
	int unsigned quiet_cycles = 0;
	int unsigned words_sent = 0;

	bit          phase_signed [PHASE_COUNT];
	logic [63:0] phase_max [PHASE_COUNT];

	text_case_t text_cases [$] = '{
		'{-1, "0",                       1'b1, 64'd0,          1'b0, STATUS_OK},
		'{-1, "2147483647",              1'b1, 64'd2147483647, 1'b0, STATUS_OK},
		'{-1, "2147483647.0",            1'b1, 64'd2147483647, 1'b0, STATUS_OK},
		'{-1, "2147483647.5",            1'b1, 64'd2147483647, 1'b0, STATUS_RANGE},
		'{-1, "-2147483648",             1'b1, 64'd2147483647, 1'b1, STATUS_RANGE},
		'{-1, "18446744073709551615",    1'b1, 64'd2147483647, 1'b0, STATUS_RANGE},
		'{-1, "99999999999999999999999", 1'b1, 64'd2147483647, 1'b0, STATUS_RANGE},
		'{-1, "-",                       1'b1, 64'd0,          1'b0, STATUS_EMPTY},
		'{127, " ",                      1'b1, 64'd0,          1'b0, STATUS_EMPTY},
		'{0, "",                         1'b1, 64'd0,          1'b0, STATUS_EMPTY},
		'{31, "\t -",                    1'b1, 64'd0,          1'b0, STATUS_EMPTY},
		'{-1, "12 ",                     1'b1, 64'd0,          1'b0, STATUS_FORMAT},
		'{-1, "5\t3",                    1'b1, 64'd0,          1'b0, STATUS_FORMAT},
		'{-1, "3-",                      1'b1, 64'd0,          1'b0, STATUS_FORMAT},
		'{-1, "--4",                     1'b1, 64'd0,          1'b0, STATUS_FORMAT},
		'{-1, ".5",                      1'b1, 64'd0,          1'b0, STATUS_FORMAT},
		'{-1, "1.2,3",                   1'b1, 64'd0,          1'b0, STATUS_FORMAT},
		'{-1, "12a",                     1'b1, 64'd0,          1'b0, STATUS_FORMAT},
		'{-1, "1x-.",                    1'b1, 64'd0,          1'b0, STATUS_FORMAT},
		'{-1, "/:",                      1'b1, 64'd0,          1'b0, STATUS_FORMAT},
		'{128, "1",                      1'b1, 64'd0,          1'b0, STATUS_FORMAT},
		'{255, "",                       1'b1, 64'd0,          1'b0, STATUS_FORMAT},
		'{-1, "  -12,9",                 1'b0, 64'd0,          1'b0, STATUS_OK},
		'{9, "\n 042.70",                1'b0, 64'd0,          1'b0, STATUS_OK},
		'{-1, "-0",                      1'b0, 64'd0,          1'b0, STATUS_OK}
	};

	decimal_text_to_integer #(
		.VALUE_BITS(VALUE_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.character(character),
		.last     (last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.magnitude(magnitude),
		.negative (negative),
		.status   (status),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advances the parse by one character. Once the string is malformed, the
	// rest of it is ignored.
	function automatic void scan_char(logic [7:0] ch);
		logic [63:0] digit;
		if (text_flags.format_error)
			return;
		if (ch < CHAR_SPACE || ch == CHAR_DEL || ch == CHAR_SPACE) begin
			// Blanks are skipped only ahead of the number.
			if (text_flags.seen_digit)
				text_flags.format_error = 1'b1;
		end else if (ch == CHAR_MINUS) begin
			if (cfg_signed && !text_flags.seen_digit && !text_flags.minus_seen)
				text_flags.minus_seen = 1'b1;
			else
				text_flags.format_error = 1'b1;
		end else if (ch == CHAR_POINT || ch == CHAR_COMMA) begin
			if (text_flags.seen_digit && !text_flags.point_seen)
				text_flags.point_seen = 1'b1;
			else
				text_flags.format_error = 1'b1;
		end else if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
			text_flags.format_error = 1'b1;
		end else begin
			text_flags.seen_digit = 1'b1;
			digit = 64'(ch - CHAR_ZERO);
			if (text_flags.point_seen) begin
				// Fraction digits only matter for the tie with the maximum.
				if (digit != 0)
					text_flags.fraction_nonzero = 1'b1;
			end else if (text_flags.too_large ||
					int_part > (VALUE_MASK - digit) / DECIMAL_BASE) begin
				// The integer part sticks at all ones once it no longer fits.
				text_flags.too_large = 1'b1;
				int_part = VALUE_MASK;
			end else begin
				int_part = int_part * DECIMAL_BASE + digit;
			end
		end
	endfunction

	// Builds the result of a finished string and starts a fresh one. The range
	// check uses the maximum held at the moment the last character arrives.
	function automatic result_t close_text();
		result_t res;
		res = '{magnitude: '0, negative: 1'b0, status: STATUS_OK};
		if (text_flags.format_error) begin
			res.status = STATUS_FORMAT;
		end else if (!text_flags.seen_digit) begin
			res.status = STATUS_EMPTY;
		end else begin
			res.negative = text_flags.minus_seen;
			if (text_flags.too_large || int_part > cfg_max ||
					(int_part == cfg_max && text_flags.fraction_nonzero)) begin
				res.status = STATUS_RANGE;
				res.magnitude = VALUE_BITS'(cfg_max & VALUE_MASK);
			end else begin
				res.magnitude = VALUE_BITS'(int_part);
			end
		end
		text_flags = '0;
		int_part = '0;
		return res;
	endfunction

	function automatic void note_failure(string msg);
		failures++;
		if (failures <= MAX_REPORTED)
			$display("%0t: %s", $time, msg);
	endfunction

	// Both channels are sampled at the rising edge, where the inputs driven at
	// the falling edge are stable and the block's outputs still hold their
	// values from before the edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			scan_char(character);
			if (last) begin
				predicted = close_text();
				pending_results.push_back(use_typed ? typed_result : predicted);
			end
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf(
					"result word with nothing expected: magnitude %0d negative %0d status %0d",
					magnitude, negative, status));
			end else begin
				wanted = pending_results.pop_front();
				if (magnitude !== wanted.magnitude || negative !== wanted.negative ||
						status !== wanted.status)
					note_failure($sformatf({"result mismatch: magnitude %0d/%0d ",
						"negative %0d/%0d status %0d/%0d (expected/actual)"},
						wanted.magnitude, magnitude, wanted.negative, negative,
						wanted.status, status));
			end
		end
	end

	// The run is abandoned when neither channel moves a word for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// The result side stalls at random, except in the quiet phase.
	always @(negedge clk)
		out_stall <= idle_enabled && ($urandom_range(99) < IDLE_PERCENT);

	// Presents one character word, with random gaps ahead of it, and holds it
	// until the block takes it. Starts and ends at a falling edge.
	task automatic send_word(logic [7:0] ch, logic is_last);
		while (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		character <= ch;
		last      <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	// Sends the first count bytes of the prepared text; closes marks the end.
	task automatic send_text(int count, bit closes);
		for (int i = 0; i < count; i++)
			send_word(text_bytes[i], closes && (i == count - 1));
	endtask

	// Setup cycle, then access cycle; the register takes the value at the edge
	// where the access completes, and the shadow copy follows it there.
	task automatic write_register(logic index, logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_BITS'({index, 3'b000});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (index == REG_SIGNED_TARGET)
			cfg_signed = value[0];
		else
			cfg_max = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Waits for every expected result, then lets the pipeline run empty.
	task automatic drain_results(int unsigned tail);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (tail)
			@(negedge clk);
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(2))
			0:       return CHAR_SPACE;
			1:       return 8'($urandom_range(31));
			default: return CHAR_DEL;
		endcase
	endfunction

	function automatic logic [7:0] pick_stray();
		case ($urandom_range(3))
			0:       return CHAR_MINUS;
			1:       return CHAR_POINT;
			2:       return CHAR_COMMA;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Values cluster around the current maximum and the top of the 64-bit
	// range, where the range check and the saturation live.
	function automatic logic [63:0] pick_magnitude();
		case ($urandom_range(7))
			0:       return 64'($urandom_range(9));
			1:       return 64'($urandom_range(99999));
			2:       return {$urandom, $urandom};
			3:       return cfg_max;
			4:       return cfg_max + 64'd1;
			5:       return cfg_max - 64'd1;
			6:       return {$urandom, $urandom} >> $urandom_range(63);
			default: return VALUE_MASK - 64'($urandom_range(3));
		endcase
	endfunction

	function automatic void append_decimal(logic [63:0] value);
		logic [7:0] digits [$];
		do begin
			digits.push_front(CHAR_ZERO + 8'(value % DECIMAL_BASE));
			value = value / DECIMAL_BASE;
		end while (value != 0);
		foreach (digits[i])
			text_bytes.push_back(digits[i]);
	endfunction

	// Mostly well-formed numbers with random blanks, sign, leading zeros and
	// fraction; a share carries a stray byte, and a few are pure noise.
	function automatic void compose_text();
		int  count;
		int  pos;
		bit  zero_fraction;
		text_bytes.delete();
		if ($urandom_range(19) == 0) begin
			count = $urandom_range(6, 1);
			repeat (count)
				text_bytes.push_back(8'($urandom_range(255)));
			return;
		end
		repeat ($urandom_range(3))
			text_bytes.push_back(pick_blank());
		if ($urandom_range(9) < 4)
			text_bytes.push_back(CHAR_MINUS);
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(2, 1))
				text_bytes.push_back(CHAR_ZERO);
		if ($urandom_range(11) == 0)
			repeat ($urandom_range(24, 20))
				text_bytes.push_back(CHAR_NINE);
		else
			append_decimal(pick_magnitude());
		if ($urandom_range(3) == 0) begin
			text_bytes.push_back($urandom_range(1) ? CHAR_POINT : CHAR_COMMA);
			count = $urandom_range(3);
			zero_fraction = 1'($urandom_range(1));
			repeat (count)
				text_bytes.push_back(zero_fraction ? CHAR_ZERO :
					CHAR_ZERO + 8'($urandom_range(9)));
		end
		if ($urandom_range(5) == 0) begin
			pos = $urandom_range(text_bytes.size() - 1);
			case ($urandom_range(2))
				0:       text_bytes[pos] = 8'($urandom_range(255));
				1:       text_bytes.insert(pos, pick_stray());
				default: text_bytes.push_back(pick_blank());
			endcase
		end
	endfunction

	initial begin
		int unsigned phase_end;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		character  <= '0;
		last       <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		cfg_signed   = 1'b1;
		cfg_max      = MAX_VALUE_RESET;
		text_flags   = '0;
		int_part     = '0;
		use_typed    = 1'b0;
		idle_enabled = 1'b1;

		// Settings for the random phases, the extremes of both registers among
		// them; one maximum is drawn at random.
		phase_signed = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		phase_max    = '{64'hFFFF_FFFF, 64'd0, VALUE_MASK, 64'd255, 64'd0,
			64'h7FFF_FFFF_FFFF_FFFF, 64'd9999, VALUE_MASK};
		phase_max[4] = {$urandom, $urandom};

		repeat (RESET_CYCLES)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed strings run with the registers as reset leaves them.
		foreach (text_cases[n]) begin
			text_bytes.delete();
			if (text_cases[n].lead >= 0)
				text_bytes.push_back(8'(text_cases[n].lead));
			for (int i = 0; i < text_cases[n].text.len(); i++)
				text_bytes.push_back(text_cases[n].text[i]);
			typed_result = '{magnitude: VALUE_BITS'(text_cases[n].magnitude),
				negative: text_cases[n].negative, status: text_cases[n].status};
			use_typed = text_cases[n].typed;
			send_text(text_bytes.size(), 1'b1);
		end
		use_typed = 1'b0;

		// Random phases. Some end in the middle of a string, so the next
		// setting applies to a string already under way.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain_results(SETTLE_CYCLES);
			write_register(REG_SIGNED_TARGET, 64'(phase_signed[p]));
			write_register(REG_MAX_VALUE, phase_max[p]);
			idle_enabled = (p != QUIET_PHASE);
			phase_end = words_sent + WORD_TARGET / PHASE_COUNT;
			while (words_sent < phase_end) begin
				compose_text();
				send_text(text_bytes.size(), 1'b1);
			end
			if (p != PHASE_COUNT - 1 && $urandom_range(1)) begin
				compose_text();
				send_text($urandom_range(text_bytes.size(), 1), 1'b0);
			end
		end

		drain_results(DRAIN_CYCLES);
		if (failures == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
